// File: hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
package i2cms_pkg;

  // largest accepted byte count
  localparam int unsigned MAX_COUNT = 255;

  // command codes
  localparam logic [1:0] OP_START_WR = 2'd0;
  localparam logic [1:0] OP_START_RD = 2'd1;
  localparam logic [1:0] OP_EVENT    = 2'd2;
  localparam logic [1:0] OP_ABORT    = 2'd3;

  // engine status codes
  localparam logic [7:0] SC_START      = 8'h08;
  localparam logic [7:0] SC_RESTART    = 8'h10;
  localparam logic [7:0] SC_SLAW_ACK   = 8'h18;
  localparam logic [7:0] SC_SLAW_NACK  = 8'h20;
  localparam logic [7:0] SC_DATW_ACK   = 8'h28;
  localparam logic [7:0] SC_DATW_NACK  = 8'h30;
  localparam logic [7:0] SC_ARB_LOST   = 8'h38;
  localparam logic [7:0] SC_SLAR_ACK   = 8'h40;
  localparam logic [7:0] SC_SLAR_NACK  = 8'h48;
  localparam logic [7:0] SC_DATR_ACK   = 8'h50;
  localparam logic [7:0] SC_DATR_NACK  = 8'h58;

  // control set bits
  localparam logic [3:0] SET_EN  = 4'b0001;
  localparam logic [3:0] SET_STA = 4'b0010;
  localparam logic [3:0] SET_STO = 4'b0100;
  localparam logic [3:0] SET_AA  = 4'b1000;

  // control clear bits
  localparam logic [3:0] CLR_EN  = 4'b0001;
  localparam logic [3:0] CLR_STA = 4'b0010;
  localparam logic [3:0] CLR_SI  = 4'b0100;
  localparam logic [3:0] CLR_AA  = 4'b1000;

  // retry timer commands
  localparam logic [1:0] RT_NONE  = 2'd0;
  localparam logic [1:0] RT_START = 2'd1;
  localparam logic [1:0] RT_STOP  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ERR  = 2'd2
  } xfer_status_t;

  typedef enum logic [1:0] {
    PH_DUMMY = 2'd0,
    PH_LOWER = 2'd1,
    PH_DATA  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slave_addr;
    logic [15:0] mem_addr;
    logic        addr_wide;
    logic [7:0]  byte_count;
    logic [7:0]  status_code;
    logic [7:0]  received_byte;
    logic [7:0]  next_write_byte;
    logic        retry_expired;
  } in_item_t;

  typedef struct packed {
    logic        load_data;
    logic [7:0]  tx_byte;
    logic [3:0]  set_mask;
    logic [3:0]  clear_mask;
    logic [1:0]  retry_timer_cmd;
    logic        write_byte_used;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [1:0]  xfer_status;
    logic        rejected;
  } out_item_t;

  // transfer context kept between items
  typedef struct packed {
    logic         is_read;
    phase_t       phase;
    xfer_status_t status;
    logic [7:0]   remaining;
    logic [7:0]   target_addr;
    logic [15:0]  memory_addr;
    logic         wide_addr;
  } seq_state_t;

endpackage

// File: hw/rtl/i2cms_if.sv
`timescale 1ns / 1ps
// command channel
interface i2cms_in_if;
  import i2cms_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface i2cms_out_if;
  import i2cms_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/i2cms_step.sv
`timescale 1ns / 1ps
module i2cms_step (
  input  i2cms_pkg::in_item_t   item,
  input  i2cms_pkg::seq_state_t st,
  output i2cms_pkg::seq_state_t st_next,
  output i2cms_pkg::out_item_t  res
);
  import i2cms_pkg::*;

  logic       sla_rd;
  logic [7:0] rem_dec;

  // read address goes out only after the dummy write
  assign sla_rd  = st.is_read && (st.phase != PH_DUMMY);
  assign rem_dec = (st.remaining != 8'd0) ? st.remaining - 8'd1 : 8'd0;

  always_comb begin
    res     = '0;
    st_next = st;
    if ((item.op == OP_START_WR) || (item.op == OP_START_RD)) begin
      // start command
      if ((item.byte_count == 8'd0) || ({1'b0, item.byte_count} > 9'(MAX_COUNT)) ||
          (st.status == ST_BUSY)) begin
        res.rejected = 1'b1;
      end else begin
        st_next.is_read     = (item.op == OP_START_RD);
        st_next.phase       = PH_DUMMY;
        st_next.remaining   = item.byte_count;
        st_next.target_addr = item.slave_addr;
        st_next.memory_addr = item.mem_addr;
        st_next.wide_addr   = item.addr_wide;
        st_next.status      = ST_BUSY;
        res.set_mask        = SET_EN | SET_STA;
        res.clear_mask      = CLR_EN | CLR_STA | CLR_SI | CLR_AA;
      end
    end else if (st.status == ST_BUSY) begin
      if (item.op == OP_ABORT) begin
        res.set_mask   = SET_STO;
        res.clear_mask = CLR_SI;
        st_next.status = ST_ERR;
      end else begin
        // bus status event
        unique case (item.status_code)
          SC_START, SC_RESTART: begin
            res.load_data  = 1'b1;
            res.tx_byte    = {st.target_addr[7:1], sla_rd};
            res.set_mask   = SET_AA;
            res.clear_mask = CLR_STA | CLR_SI;
            if ((item.status_code == SC_START) && !sla_rd) begin
              res.retry_timer_cmd = RT_START;
            end
          end
          SC_SLAW_ACK: begin
            res.retry_timer_cmd = RT_STOP;
            res.load_data       = 1'b1;
            res.set_mask        = SET_AA;
            res.clear_mask      = CLR_SI;
            if (st.wide_addr) begin
              res.tx_byte   = st.memory_addr[15:8];
              st_next.phase = PH_LOWER;
            end else begin
              res.tx_byte   = st.memory_addr[7:0];
              st_next.phase = PH_DATA;
            end
          end
          SC_SLAW_NACK: begin
            if (item.retry_expired) begin
              res.retry_timer_cmd = RT_STOP;
              res.set_mask        = SET_STO;
              res.clear_mask      = CLR_SI;
              st_next.status      = ST_ERR;
            end else begin
              res.set_mask   = SET_STA | SET_AA;
              res.clear_mask = CLR_SI;
            end
          end
          SC_DATW_ACK: begin
            unique case (st.phase)
              PH_LOWER: begin
                res.load_data  = 1'b1;
                res.tx_byte    = st.memory_addr[7:0];
                res.set_mask   = SET_AA;
                res.clear_mask = CLR_SI;
                st_next.phase  = PH_DATA;
              end
              PH_DATA: begin
                if (st.is_read) begin
                  res.set_mask   = SET_STA;
                  res.clear_mask = CLR_SI;
                end else if (st.remaining != 8'd0) begin
                  res.load_data       = 1'b1;
                  res.tx_byte         = item.next_write_byte;
                  res.write_byte_used = 1'b1;
                  res.set_mask        = SET_AA;
                  res.clear_mask      = CLR_SI;
                  st_next.remaining   = rem_dec;
                end else begin
                  res.set_mask   = SET_STO;
                  res.clear_mask = CLR_SI;
                  st_next.phase  = PH_DONE;
                  st_next.status = ST_OK;
                end
              end
              PH_DONE: begin
                res.set_mask   = SET_STO;
                res.clear_mask = CLR_SI;
                st_next.status = ST_OK;
              end
              PH_DUMMY: begin
                res.set_mask   = SET_STO;
                res.clear_mask = CLR_SI;
                st_next.status = ST_ERR;
              end
              default: ;
            endcase
          end
          SC_ARB_LOST: begin
            res.set_mask   = SET_STA | SET_AA;
            res.clear_mask = CLR_SI;
            st_next.status = ST_ERR;
          end
          SC_SLAR_ACK: begin
            // a lone byte is nacked
            if (st.remaining == 8'd1) begin
              res.clear_mask = CLR_SI | CLR_AA;
            end else begin
              res.set_mask   = SET_AA;
              res.clear_mask = CLR_SI;
            end
          end
          SC_DATR_ACK: begin
            res.read_valid    = 1'b1;
            res.read_byte     = item.received_byte;
            st_next.remaining = rem_dec;
            if (rem_dec == 8'd1) begin
              res.clear_mask = CLR_SI | CLR_AA;
            end else if (rem_dec == 8'd0) begin
              res.set_mask   = SET_STO;
              res.clear_mask = CLR_SI;
              st_next.status = ST_OK;
            end else begin
              res.set_mask   = SET_AA;
              res.clear_mask = CLR_SI;
            end
          end
          SC_DATR_NACK: begin
            res.read_valid    = 1'b1;
            res.read_byte     = item.received_byte;
            st_next.remaining = 8'd0;
            res.set_mask      = SET_STO;
            res.clear_mask    = CLR_SI;
            st_next.status    = ST_OK;
          end
          default: begin
            // data nack, address nack on read, unknown code
            res.set_mask   = SET_STO;
            res.clear_mask = CLR_SI;
            st_next.status = ST_ERR;
          end
        endcase
      end
    end
    res.xfer_status = st_next.status;
  end

endmodule

// File: hw/rtl/i2c_master_eeprom_sequencer.sv
`timescale 1ns / 1ps
// I2C memory-transfer sequencer: each command or engine status event on cmd
// yields exactly one control word on res. Throughput is one item per clock
// while res does not stall; an item passes an input register and then the
// result register, with the transfer context updated as the item moves from
// one to the other, so an item always sees the context left by the item
// before it. A stalled result stage holds the input stage, and cmd keeps
// taking items while either stage has room.
module i2c_master_eeprom_sequencer (
  input logic        clk,
  input logic        rst,
  i2cms_in_if.sink   cmd,
  i2cms_out_if.source res
);
  import i2cms_pkg::*;

  logic       in_valid;
  in_item_t   in_item;
  seq_state_t st;
  seq_state_t st_next;
  out_item_t  step_res;
  logic       out_valid;
  out_item_t  out_item;
  logic       advance;

  // input stage moves on when the result register is free or being taken
  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;
  assign res.valid = out_valid;
  assign res.data  = out_item;

  i2cms_step u_step (
    .item    (in_item),
    .st      (st),
    .st_next (st_next),
    .res     (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.data;
    end
  end

  // transfer context
  always_ff @(posedge clk) begin
    if (rst) begin
      st.is_read     <= 1'b0;
      st.phase       <= PH_DUMMY;
      st.status      <= ST_OK;
      st.remaining   <= 8'd0;
      st.target_addr <= 8'd0;
      st.memory_addr <= 16'd0;
      st.wide_addr   <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= step_res;
    end
  end

endmodule
